// File: rtl/pal_pkg.sv
// Shared types and constants for the positional array list.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package pal_pkg;

	// Default number of slots in the list.
	localparam int DEPTH_DEF = 64;

	// Width of one list element.
	localparam int DATA_W = 32;

	// Command codes carried on the command field.
	typedef enum logic [3:0] {
		CMD_INSERT_AT    = 4'd0,
		CMD_INSERT_FRONT = 4'd1,
		CMD_INSERT_BACK  = 4'd2,
		CMD_REMOVE_AT    = 4'd3,
		CMD_MODIFY       = 4'd4,
		CMD_READ         = 4'd5,
		CMD_LOCATE       = 4'd6,
		CMD_REMOVE_ALL   = 4'd7,
		CMD_CLEAR        = 4'd8
	} cmd_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// Operation broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		OP_HOLD = 3'd0,
		OP_INS  = 3'd1,
		OP_DEL  = 3'd2,
		OP_WR   = 3'd3,
		OP_ROT  = 3'd4
	} cell_op_t;

	// Control group sent from the sequencer to the cell row.
	typedef struct packed {
		cell_op_t          op;
		logic [DATA_W-1:0] value;
	} cell_ctl_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_SCAN = 2'd2,
		S_DONE = 2'd3
	} state_t;

endpackage

// File: rtl/positional_array_list_top.sv
// Positional array list: an ordered list of signed 32-bit values in a chain of DEPTH cells.
// Depends on pal_pkg and pal_chain.
`timescale 1ns / 1ps

// The block keeps an ordered list of up to DEPTH signed 32-bit elements and
// takes one command per input beat: insert at a position, at the front or at
// the back, remove at a position, overwrite, read, locate the first match,
// remove every match, or clear. Each command gives exactly one result beat
// with a status, the element read, the index found and the length held
// afterwards. The elements live in a row of cells, one element per cell;
// inserts and removes shift the tail of the row by one cell in one update.
// Read, locate and remove-all rotate the occupied part of the row through
// cell 0 one element per cycle; only an in-range read and a locate or
// remove-all on a non-empty list do so, while insert, remove, modify, clear,
// unknown codes, a read that fails its range check and any command on an
// empty list skip the rotation. The next command beat can be taken in the
// same cycle as the result is offered. One command is in flight at a time; a
// new command beat is taken as soon as the previous result sits in the output
// register, even while that result is still stalled. The store has no reset
// and needs no clearing pass: only elements below the length are ever read.
module positional_array_list_top #(
	parameter int DEPTH = pal_pkg::DEPTH_DEF,
	localparam int PW = $clog2(DEPTH + 1),
	localparam int IW = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Command channel.
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  logic [3:0]                        command,
	input  logic [PW-1:0]                     position,
	input  logic signed [pal_pkg::DATA_W-1:0] value,
	// Result channel.
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [2:0]                        status,
	output logic signed [pal_pkg::DATA_W-1:0] read_data,
	output logic [IW-1:0]                     found_index,
	output logic [PW-1:0]                     length
);

	localparam logic [PW-1:0] DEPTH_PW = PW'(DEPTH);
	localparam logic [PW-1:0] ONE_PW   = PW'(1);

	pal_pkg::state_t state_q, state_d;

	// Latched command beat.
	pal_pkg::cmd_t              cmd_q;
	logic [PW-1:0]              pos_q;
	logic [pal_pkg::DATA_W-1:0] val_q;

	// Length of the list; during remove-all it tracks the shrinking list.
	logic [PW-1:0] count_q;

	// Rotation progress: elements already passed through cell 0 and lap length.
	logic [PW-1:0] step_q;
	logic [PW-1:0] total_q;

	// Result under construction.
	pal_pkg::status_t           st_q;
	logic [pal_pkg::DATA_W-1:0] rd_q;
	logic [IW-1:0]              fi_q;

	// Output register.
	logic                       rsp_valid_q;
	logic [2:0]                 status_q;
	logic [pal_pkg::DATA_W-1:0] read_data_q;
	logic [IW-1:0]              found_index_q;
	logic [PW-1:0]              length_q;

	// Chain interface.
	pal_pkg::cell_ctl_t         ctl;
	logic [PW-1:0]              ctl_pos;
	logic [pal_pkg::DATA_W-1:0] head_data;

	// Command decode, valid while the latched command sits in S_EXEC.
	logic [PW-1:0]      ins_pos;
	pal_pkg::status_t   exec_status;
	pal_pkg::cell_op_t  exec_op;
	logic [PW-1:0]      exec_pos;
	logic [PW-1:0]      exec_count;
	logic               scan_go;

	logic cmd_take;
	logic out_free;
	logic load_out;
	logic scan_last;
	logic head_match;

	assign cmd_take   = cmd_valid && !cmd_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign scan_last  = (step_q + ONE_PW) == total_q;
	assign head_match = head_data == val_q;

	// Work out status, chain operation and new length for each command.
	// Insert checks run in order: full, then empty (goes to slot 0), then range.
	always_comb begin
		ins_pos     = pos_q;
		exec_status = pal_pkg::ST_OK;
		exec_op     = pal_pkg::OP_HOLD;
		exec_pos    = pos_q;
		exec_count  = count_q;
		scan_go     = 1'b0;

		case (cmd_q)
			pal_pkg::CMD_INSERT_FRONT: ins_pos = '0;
			pal_pkg::CMD_INSERT_BACK:  ins_pos = count_q;
			default:                   ins_pos = pos_q;
		endcase

		case (cmd_q)
			pal_pkg::CMD_INSERT_AT, pal_pkg::CMD_INSERT_FRONT,
			pal_pkg::CMD_INSERT_BACK: begin
				if (count_q >= DEPTH_PW) begin
					exec_status = pal_pkg::ST_FULL;
				end else if (count_q == '0) begin
					exec_op    = pal_pkg::OP_INS;
					exec_pos   = '0;
					exec_count = ONE_PW;
				end else if (ins_pos > count_q) begin
					exec_status = pal_pkg::ST_BADPOS;
				end else begin
					exec_op    = pal_pkg::OP_INS;
					exec_pos   = ins_pos;
					exec_count = count_q + ONE_PW;
				end
			end
			pal_pkg::CMD_REMOVE_AT, pal_pkg::CMD_MODIFY, pal_pkg::CMD_READ: begin
				if (count_q == '0) begin
					exec_status = pal_pkg::ST_EMPTY;
				end else if (pos_q >= count_q) begin
					exec_status = pal_pkg::ST_BADPOS;
				end else if (cmd_q == pal_pkg::CMD_REMOVE_AT) begin
					exec_op    = pal_pkg::OP_DEL;
					exec_count = count_q - ONE_PW;
				end else if (cmd_q == pal_pkg::CMD_MODIFY) begin
					exec_op = pal_pkg::OP_WR;
				end else begin
					scan_go = 1'b1;
				end
			end
			pal_pkg::CMD_LOCATE: begin
				exec_status = pal_pkg::ST_NOTFOUND;
				scan_go     = count_q != '0;
			end
			pal_pkg::CMD_REMOVE_ALL: begin
				scan_go = count_q != '0;
			end
			pal_pkg::CMD_CLEAR: begin
				exec_count = '0;
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pal_pkg::S_IDLE: begin
				if (cmd_valid) begin
					state_d = pal_pkg::S_EXEC;
				end
			end
			pal_pkg::S_EXEC: begin
				state_d = scan_go ? pal_pkg::S_SCAN : pal_pkg::S_DONE;
			end
			pal_pkg::S_SCAN: begin
				if (scan_last) begin
					state_d = pal_pkg::S_DONE;
				end
			end
			pal_pkg::S_DONE: begin
				if (out_free) begin
					state_d = pal_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pal_pkg::S_IDLE;
			end
		endcase
	end

	// State outputs: handshake and the operation driven onto the cell row.
	// During a lap, a matching head under remove-all is dropped by shifting
	// the row down from cell 0; every other head wraps to the last slot.
	always_comb begin
		cmd_stall = 1'b1;
		load_out  = 1'b0;
		ctl.op    = pal_pkg::OP_HOLD;
		ctl.value = val_q;
		ctl_pos   = exec_pos;
		case (state_q)
			pal_pkg::S_IDLE: begin
				cmd_stall = 1'b0;
			end
			pal_pkg::S_EXEC: begin
				ctl.op = exec_op;
			end
			pal_pkg::S_SCAN: begin
				if (cmd_q == pal_pkg::CMD_REMOVE_ALL && head_match) begin
					ctl.op  = pal_pkg::OP_DEL;
					ctl_pos = '0;
				end else begin
					ctl.op = pal_pkg::OP_ROT;
				end
			end
			pal_pkg::S_DONE: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	pal_chain #(
		.DEPTH (DEPTH)
	) u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.pos       (ctl_pos),
		.len       (count_q),
		.head_data (head_data)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pal_pkg::S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pal_pkg::S_EXEC) begin
				count_q <= exec_count;
			end else if (ctl.op == pal_pkg::OP_DEL && state_q == pal_pkg::S_SCAN) begin
				count_q <= count_q - ONE_PW;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Command latch, lap bookkeeping and result payload.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= pal_pkg::cmd_t'(command);
			pos_q <= position;
			val_q <= value;
		end

		if (state_q == pal_pkg::S_EXEC) begin
			st_q    <= exec_status;
			rd_q    <= '0;
			fi_q    <= '0;
			step_q  <= '0;
			total_q <= count_q;
		end else if (state_q == pal_pkg::S_SCAN) begin
			step_q <= step_q + ONE_PW;
			if (cmd_q == pal_pkg::CMD_READ && step_q == pos_q) begin
				rd_q <= head_data;
			end
			if (cmd_q == pal_pkg::CMD_LOCATE && head_match
					&& st_q == pal_pkg::ST_NOTFOUND) begin
				st_q <= pal_pkg::ST_OK;
				fi_q <= step_q[IW-1:0];
			end
		end

		if (load_out) begin
			status_q      <= st_q;
			read_data_q   <= rd_q;
			found_index_q <= fi_q;
			length_q      <= count_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign read_data   = read_data_q;
	assign found_index = found_index_q;
	assign length      = length_q;

endmodule

// File: rtl/pal_cell.sv
// One storage cell of the list chain: holds a single element and loads from a neighbor, the command value or the head.
// Depends on pal_pkg for the cell control group.
`timescale 1ns / 1ps

module pal_cell #(
	parameter int DEPTH = pal_pkg::DEPTH_DEF,
	parameter int INDEX = 0,
	localparam int PW = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  pal_pkg::cell_ctl_t         ctl,
	input  logic [PW-1:0]              pos,
	input  logic [PW-1:0]              len,
	input  logic [pal_pkg::DATA_W-1:0] left_data,
	input  logic [pal_pkg::DATA_W-1:0] right_data,
	input  logic [pal_pkg::DATA_W-1:0] head_data,
	output logic [pal_pkg::DATA_W-1:0] data
);

	localparam logic [PW-1:0] IDX    = PW'(INDEX);
	localparam logic [PW-1:0] IDX_P1 = PW'(INDEX + 1);

	logic [pal_pkg::DATA_W-1:0] data_q;

	// Rotation moves the valid region left by one and wraps the head to the
	// last valid slot, so a full lap brings every element past cell 0.
	always_ff @(posedge clk) begin
		case (ctl.op)
			pal_pkg::OP_INS: begin
				if (IDX > pos) begin
					data_q <= left_data;
				end else if (IDX == pos) begin
					data_q <= ctl.value;
				end
			end
			pal_pkg::OP_DEL: begin
				if (IDX >= pos) begin
					data_q <= right_data;
				end
			end
			pal_pkg::OP_WR: begin
				if (IDX == pos) begin
					data_q <= ctl.value;
				end
			end
			pal_pkg::OP_ROT: begin
				if (IDX_P1 < len) begin
					data_q <= right_data;
				end else if (IDX_P1 == len) begin
					data_q <= head_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

endmodule

// File: rtl/pal_chain.sv
// Row of list cells wired to their neighbors, with cell 0 exposed as the head.
// Depends on pal_pkg and pal_cell.
`timescale 1ns / 1ps

module pal_chain #(
	parameter int DEPTH = pal_pkg::DEPTH_DEF,
	localparam int PW = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  pal_pkg::cell_ctl_t         ctl,
	input  logic [PW-1:0]              pos,
	input  logic [PW-1:0]              len,
	output logic [pal_pkg::DATA_W-1:0] head_data
);

	logic [pal_pkg::DATA_W-1:0] cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int LI = (i == 0) ? 0 : i - 1;
		localparam int RI = (i == DEPTH - 1) ? i : i + 1;

		pal_cell #(
			.DEPTH (DEPTH),
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.pos        (pos),
			.len        (len),
			.left_data  (cell_data[LI]),
			.right_data (cell_data[RI]),
			.head_data  (cell_data[0]),
			.data       (cell_data[i])
		);
	end

	assign head_data = cell_data[0];

endmodule

// File: rtl/pal_checker.sv
// Port-level checks for the positional array list, bound to the top level.
// Depends on pal_pkg and positional_array_list_top.
`timescale 1ns / 1ps

module pal_checker #(
	parameter int DEPTH = pal_pkg::DEPTH_DEF,
	localparam int PW = $clog2(DEPTH + 1),
	localparam int IW = $clog2(DEPTH)
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_stall,
	input logic [2:0]                 status,
	input logic [pal_pkg::DATA_W-1:0] read_data,
	input logic [IW-1:0]              found_index,
	input logic [PW-1:0]              length
);

	// A stalled result beat holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(read_data)
			&& $stable(found_index) && $stable(length))
		else $error("result beat changed while stalled");

	// Full is only reported with every slot taken.
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == pal_pkg::ST_FULL |-> length == PW'(DEPTH))
		else $error("full status with free slots");

	// Empty is only reported on an empty list, and length never exceeds the store.
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> length <= PW'(DEPTH)
			&& (status != pal_pkg::ST_EMPTY || length == '0))
		else $error("length inconsistent with status");

	// Failed commands return no data and no index.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != pal_pkg::ST_OK |-> read_data == '0 && found_index == '0)
		else $error("nonzero payload on failed command");

endmodule

bind positional_array_list_top pal_checker #(
	.DEPTH (DEPTH)
) u_pal_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.status      (status),
	.read_data   (read_data),
	.found_index (found_index),
	.length      (length)
);

// File: test/pal_checker.sv
// Scoreboard for the positional array list: watches both channels and predicts every result.
// Depends on pal_pkg; instantiated by tb beside positional_array_list_top.
`timescale 1ns / 1ps

module pal_scoreboard #(
	parameter int DEPTH = pal_pkg::DEPTH_DEF,
	localparam int PW = $clog2(DEPTH + 1),
	localparam int IW = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	input  logic                              cmd_stall,
	input  logic [3:0]                        command,
	input  logic [PW-1:0]                     position,
	input  logic signed [pal_pkg::DATA_W-1:0] value,
	input  logic                              rsp_valid,
	input  logic                              rsp_stall,
	input  logic [2:0]                        status,
	input  logic signed [pal_pkg::DATA_W-1:0] read_data,
	input  logic [IW-1:0]                     found_index,
	input  logic [PW-1:0]                     length,
	output int                                fail_count,
	output int                                pending,
	output int                                held_now
);

	import pal_pkg::*;

	typedef struct packed {
		status_t           st;
		logic [DATA_W-1:0] rd;
		logic [IW-1:0]     fi;
		logic [PW-1:0]     len;
	} list_result_t;

	// Shadow copy of the list contents and its length.
	logic [DATA_W-1:0] slots [DEPTH];
	int                held = 0;
	int                mismatches = 0;
	int                waiting = 0;
	list_result_t      expected_results [$];

	assign fail_count = mismatches;
	assign pending    = waiting;
	assign held_now   = held;

	task automatic note_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// The full check comes first; an empty list takes the value at slot 0 whatever the index.
	function automatic status_t insert_value(input int at, input logic [DATA_W-1:0] v);
		if (held >= DEPTH)
			return ST_FULL;
		if (held == 0) begin
			slots[0] = v;
			held = 1;
			return ST_OK;
		end
		if (at > held)
			return ST_BADPOS;
		for (int i = held; i > at; i--)
			slots[i] = slots[i - 1];
		slots[at] = v;
		held++;
		return ST_OK;
	endfunction

	function automatic status_t index_status(input int at);
		if (held == 0)
			return ST_EMPTY;
		if (at >= held)
			return ST_BADPOS;
		return ST_OK;
	endfunction

	function automatic list_result_t run_command(input logic [3:0] code, input int at,
			input logic [DATA_W-1:0] v);
		list_result_t r;
		int           kept;
		r = '0;
		r.st = ST_OK;
		case (code)
			CMD_INSERT_AT:    r.st = insert_value(at, v);
			CMD_INSERT_FRONT: r.st = insert_value(0, v);
			CMD_INSERT_BACK:  r.st = insert_value(held, v);
			CMD_REMOVE_AT: begin
				r.st = index_status(at);
				if (r.st == ST_OK) begin
					for (int i = at; i + 1 < held; i++)
						slots[i] = slots[i + 1];
					held--;
				end
			end
			CMD_MODIFY: begin
				r.st = index_status(at);
				if (r.st == ST_OK)
					slots[at] = v;
			end
			CMD_READ: begin
				r.st = index_status(at);
				if (r.st == ST_OK)
					r.rd = slots[at];
			end
			CMD_LOCATE: begin
				r.st = ST_NOTFOUND;
				for (int i = 0; i < held && r.st != ST_OK; i++) begin
					if (slots[i] == v) begin
						r.st = ST_OK;
						r.fi = IW'(i);
					end
				end
			end
			CMD_REMOVE_ALL: begin
				kept = 0;
				for (int i = 0; i < held; i++) begin
					if (slots[i] != v) begin
						slots[kept] = slots[i];
						kept++;
					end
				end
				held = kept;
			end
			CMD_CLEAR: held = 0;
			default: ;
		endcase
		r.len = PW'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			held = 0;
			expected_results.delete();
			waiting = 0;
		end else begin
			// Results are retired before new commands so a beat on each side in one cycle is fine.
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					note_mismatch($sformatf("result beat with nothing pending, status %0d", status));
				end else begin
					want = expected_results.pop_front();
					if (status !== want.st)
						note_mismatch($sformatf("status %0d, predicted %0d", status, want.st));
					if (read_data !== want.rd)
						note_mismatch($sformatf("read_data %0h, predicted %0h", read_data, want.rd));
					if (found_index !== want.fi)
						note_mismatch($sformatf("found_index %0d, predicted %0d",
							found_index, want.fi));
					if (length !== want.len)
						note_mismatch($sformatf("length %0d, predicted %0d", length, want.len));
				end
			end
			if (cmd_valid && !cmd_stall)
				expected_results.push_back(run_command(command, int'(position), value));
			waiting = expected_results.size();
		end
	end

endmodule

// File: test/tb.sv
// Top of the positional array list testbench: clock, reset, command stimulus and verdict.
// Depends on pal_pkg, positional_array_list_top and pal_scoreboard.
`timescale 1ns / 1ps

module tb;

	import pal_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int PW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int ITEMS = 550;
	// Longest cycle count with no beat on either channel before the run is called hung.
	localparam int WATCH_LIMIT = 2000;
	// Length of the deliberate hold-off on the result side.
	localparam int HOLD_CYCLES = 160;
	// The tail wait outlasts a remove-all on a full list, which rotates every element through cell 0.
	localparam int TAIL_CYCLES = DEPTH + 10;
	// Command codes the block does not define; they must leave the list untouched.
	localparam logic [3:0] CMD_SPARE_LO = 4'd9;
	localparam logic [3:0] CMD_SPARE_HI = 4'd15;

	logic                     clk;
	logic                     arst_n;
	logic                     cmd_valid;
	logic                     cmd_stall;
	logic [3:0]               command;
	logic [PW-1:0]            position;
	logic signed [DATA_W-1:0] value;
	logic                     rsp_valid;
	logic                     rsp_stall;
	logic [2:0]               status;
	logic signed [DATA_W-1:0] read_data;
	logic [IW-1:0]            found_index;
	logic [PW-1:0]            length;

	int fail_count;
	int pending;
	int held_now;

	// Number of command beats accepted so far.
	int issued = 0;
	// While calm is set neither side idles, which gives stretches of back-to-back beats.
	bit calm = 1'b0;
	// Set by the stimulus to ask the result side for one long hold-off.
	bit hold_req = 1'b0;

	// A small pool of element values, so that locate and remove-all find matches often.
	logic [DATA_W-1:0] value_pool [8];

	positional_array_list_top #(.DEPTH(DEPTH)) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.command     (command),
		.position    (position),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.read_data   (read_data),
		.found_index (found_index),
		.length      (length)
	);

	pal_scoreboard #(.DEPTH(DEPTH)) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.command     (command),
		.position    (position),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.read_data   (read_data),
		.found_index (found_index),
		.length      (length),
		.fail_count  (fail_count),
		.pending     (pending),
		.held_now    (held_now)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Gap lengths for both sides: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 65)
			return value_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	// Indexes are mostly legal for a list of span entries, sometimes right at the
	// boundary, and sometimes anywhere in the field, out-of-range ones included.
	function automatic logic [PW-1:0] pick_index(input int span);
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return PW'($urandom_range(0, span > 0 ? span - 1 : 0));
		if (r < 90)
			return PW'(span + $urandom_range(0, 1));
		return PW'($urandom_range(0, (1 << PW) - 1));
	endfunction

	// Offers one command beat and returns at the falling edge after it was taken.
	// The caller either offers the next beat at that edge or lowers valid.
	task automatic send_cmd(input logic [3:0] code, input logic [PW-1:0] at,
			input logic [DATA_W-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		command <= code;
		position <= at;
		value <= v;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		@(negedge clk);
		issued++;
	endtask

	task automatic send_insert();
		int r;
		r = $urandom_range(0, 2);
		if (r == 0)
			send_cmd(CMD_INSERT_AT, pick_index(held_now + 1), pick_value());
		else if (r == 1)
			send_cmd(CMD_INSERT_FRONT, pick_index(DEPTH), pick_value());
		else
			send_cmd(CMD_INSERT_BACK, pick_index(DEPTH), pick_value());
	endtask

	// One command drawn from the whole set, weighted toward the cheap ones.
	task automatic send_mixed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			send_insert();
		else if (r < 44)
			send_cmd(CMD_REMOVE_AT, pick_index(held_now), pick_value());
		else if (r < 54)
			send_cmd(CMD_MODIFY, pick_index(held_now), pick_value());
		else if (r < 70)
			send_cmd(CMD_READ, pick_index(held_now), pick_value());
		else if (r < 82)
			send_cmd(CMD_LOCATE, pick_index(DEPTH), pick_value());
		else if (r < 89)
			send_cmd(CMD_REMOVE_ALL, pick_index(DEPTH), pick_value());
		else if (r < 92)
			send_cmd(CMD_CLEAR, pick_index(DEPTH), pick_value());
		else
			send_cmd(4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), pick_index(DEPTH),
				pick_value());
	endtask

	// Result side. It stalls at random, and once on request it holds off for a
	// long stretch so that the block fills up and has to stall its command input.
	initial begin
		int left;
		int spent;
		bit hold_used;
		rsp_stall = 1'b0;
		left = 0;
		hold_used = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_used) begin
				rsp_stall <= 1'b1;
				for (spent = 1; spent < HOLD_CYCLES; spent++)
					@(negedge clk);
				hold_used = 1'b1;
			end else if (left > 0) begin
				rsp_stall <= 1'b1;
				left--;
			end else begin
				rsp_stall <= 1'b0;
				if (!calm && $urandom_range(0, 99) < 30)
					left = pick_gap();
			end
		end
	end

	// Watchdog: counts cycles in which neither channel moves a beat.
	initial begin
		int idle;
		idle = 0;
		while (idle < WATCH_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				idle = 0;
			else
				idle++;
		end
		$display("positional_array_list_top: mismatch");
		$finish;
	end

	initial begin
		int  kind;
		int  n;
		int  j;
		bit  filled_once;
		bit  held_once;
		bit  paused_once;
		cmd_valid = 1'b0;
		command = '0;
		position = '0;
		value = '0;
		arst_n = 1'b0;
		filled_once = 1'b0;
		held_once = 1'b0;
		paused_once = 1'b0;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hffff_ffff;
		value_pool[2] = 32'h8000_0000;
		value_pool[3] = 32'h7fff_ffff;
		value_pool[4] = 32'h0000_0001;
		for (j = 5; j < 8; j++)
			value_pool[j] = $urandom;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every positional command on the empty list reports it empty; locate finds nothing.
		send_cmd(CMD_READ, 0, 32'h0);
		send_cmd(CMD_REMOVE_AT, 0, 32'h0);
		send_cmd(CMD_MODIFY, 0, 32'h1);
		send_cmd(CMD_LOCATE, 0, 32'h0);
		send_cmd(CMD_REMOVE_ALL, 0, 32'h0);
		// An insert into the empty list lands in slot 0 even with the largest index.
		send_cmd(CMD_INSERT_AT, 7'h7f, 32'h8000_0000);
		send_cmd(CMD_INSERT_FRONT, 0, 32'h7fff_ffff);
		send_cmd(CMD_INSERT_BACK, 0, 32'hffff_ffff);
		// Inserting right at the length appends; one past it is a bad index.
		send_cmd(CMD_INSERT_AT, 3, 32'h0);
		send_cmd(CMD_INSERT_AT, 5, 32'h1);
		send_cmd(CMD_INSERT_AT, 1, 32'h7fff_ffff);
		// The list now holds five entries; reads at both ends and just beyond.
		send_cmd(CMD_READ, 0, 32'h0);
		send_cmd(CMD_READ, 4, 32'h0);
		send_cmd(CMD_READ, 5, 32'h0);
		send_cmd(CMD_READ, 64, 32'hffff_ffff);
		send_cmd(CMD_MODIFY, 2, 32'h1234_5678);
		send_cmd(CMD_LOCATE, 0, 32'h7fff_ffff);
		send_cmd(CMD_LOCATE, 0, 32'h5555_aaaa);
		// Two copies are removed at once and the rest keep their order.
		send_cmd(CMD_REMOVE_ALL, 0, 32'h7fff_ffff);
		send_cmd(CMD_REMOVE_AT, 3, 32'h0);
		send_cmd(CMD_REMOVE_AT, 0, 32'h0);
		// Undefined codes change nothing.
		send_cmd(CMD_SPARE_LO, 7'h7f, 32'hffff_ffff);
		send_cmd(CMD_SPARE_HI, 7'h40, 32'h0);
		send_cmd(CMD_CLEAR, 0, 32'h0);
		send_cmd(CMD_READ, 0, 32'h0);

		// Random part, built from phases that grow the list, shuffle it or drain it.
		while (issued < ITEMS) begin
			calm = ($urandom_range(0, 7) == 0);
			kind = $urandom_range(0, 99);
			if (!held_once && issued > 150) begin
				// Keep offering commands while the result side holds off.
				held_once = 1'b1;
				calm = 1'b1;
				hold_req = 1'b1;
				repeat (6) send_mixed();
			end else if (!paused_once && issued > 350) begin
				// Let the block run dry before carrying on.
				paused_once = 1'b1;
				cmd_valid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end else if (!filled_once || kind < 12) begin
				// Fill to the top, then push a few more inserts against the full list.
				filled_once = 1'b1;
				for (j = 0; held_now < DEPTH && j < 200; j++)
					send_insert();
				repeat (3) send_insert();
			end else if ((held_now < 8 && kind < 60) || kind < 30) begin
				n = $urandom_range(8, 40);
				for (j = 0; j < n && held_now < DEPTH; j++)
					send_insert();
			end else if (kind < 45) begin
				for (j = 0; held_now > 0 && j < 100; j++) begin
					if ($urandom_range(0, 4) == 0)
						send_cmd(CMD_REMOVE_ALL, pick_index(DEPTH), pick_value());
					else
						send_cmd(CMD_REMOVE_AT, pick_index(held_now), pick_value());
				end
				repeat (2) send_mixed();
			end else begin
				n = $urandom_range(10, 40);
				repeat (n) send_mixed();
			end
		end
		calm = 1'b0;
		cmd_valid <= 1'b0;

		wait (pending == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("positional_array_list_top: match");
		else
			$display("positional_array_list_top: mismatch");
		$finish;
	end

endmodule

// File: positional_array_list_top.f
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/pal_chain.sv
rtl/positional_array_list_top.sv
rtl/pal_checker.sv
test/pal_checker.sv
test/tb.sv
